// ===== hdl/cdpt_pkg.sv =====
// Package for the CD-ROM command packet target.
// Holds access/result types, register and opcode codes, and BCD/length helpers.
// No dependencies.
package cdpt_pkg;

    localparam int PACKET_BYTES_DEF = 8;

    localparam logic       ACC_READ  = 1'b0;
    localparam logic       ACC_WRITE = 1'b1;

    localparam logic [1:0] REG_CMD       = 2'd0;
    localparam logic [1:0] REG_PHASE     = 2'd1;
    localparam logic [1:0] REG_AUX       = 2'd2;
    localparam logic [1:0] REG_PHASE_ALT = 2'd3;

    localparam logic [7:0] STATUS_BYTE = 8'h40;
    localparam logic [7:0] PHASE_BYTE  = 8'h0B;
    localparam logic [7:0] FLOAT_BYTE  = 8'hFF;
    localparam logic [7:0] WRITE_BYTE  = 8'h00;

    localparam logic [7:0] OP_READ     = 8'hC0;
    localparam logic [7:0] OP_PARAM3   = 8'h90;
    localparam logic [7:0] OP_PARAM2_A = 8'h50;
    localparam logic [7:0] OP_PARAM2_B = 8'hFE;
    localparam logic [7:0] OP_DATA_A   = 8'h10;
    localparam logic [7:0] OP_DATA_B   = 8'hDC;

    localparam int READ_MIN_IDX   = 1;
    localparam int READ_SEC_IDX   = 2;
    localparam int READ_FRM_IDX   = 3;
    localparam int READ_COUNT_IDX = 6;

    localparam logic [19:0] FRAMES_PER_SEC = 20'd75;
    localparam logic [19:0] FRAMES_PER_MIN = 20'd4500;
    localparam logic [19:0] LEAD_IN_FRAMES = 20'd150;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_RECEIVE  = 3'd1,
        MODE_STATUS   = 3'd2,
        MODE_DATA_OUT = 3'd3,
        MODE_READ     = 3'd4,
        MODE_ERROR    = 3'd5
    } t_mode;

    typedef struct packed {
        logic       cmd;
        logic [1:0] reg_sel;
        logic [7:0] value;
    } t_access;

    typedef struct packed {
        logic [7:0]  read_data;
        t_mode       mode;
        logic [19:0] lba;
        logic [7:0]  sectors;
    } t_result;

    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        logic [7:0] tens;
        tens = {4'd0, v[7:4]};
        return (tens << 3) + (tens << 1) + {4'd0, v[3:0]};
    endfunction

    function automatic logic [2:0] packet_length(input logic [7:0] op);
        logic [2:0] len;
        unique case (op) inside
            OP_PARAM2_A, OP_PARAM2_B: len = 3'd2;
            OP_PARAM3:                len = 3'd3;
            OP_READ:                  len = 3'd7;
            default:                  len = 3'd1;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/cdrom_command_packet_target.sv =====
// CD-ROM command packet target: input register, packet engine, result register.
// An accepted transfer is held in the input register, then moved to the result register.
// Throughput: one transfer per cycle while results are taken; the input register drains
// into the result register whenever the result register is empty or being taken.
// Reset (synchronous, active low): idle mode, empty packet store, block and count zero.
// Depends on cdpt_pkg and cdpt_packet.
module cdrom_command_packet_target #(
    parameter int PACKET_BYTES = cdpt_pkg::PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [1:0]  i_reg_select,
    input  logic [7:0]  i_write_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic [2:0]  o_drive_state,
    output logic [19:0] o_read_lba,
    output logic [7:0]  o_read_sectors
);
    import cdpt_pkg::*;

    logic    r_in_valid;
    t_access r_acc;
    logic    r_out_valid;
    t_result r_res;
    t_result res;
    logic    advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    cdpt_packet #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_packet (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (advance),
        .i_acc   (r_acc),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_acc.cmd     <= i_cmd;
            r_acc.reg_sel <= i_reg_select;
            r_acc.value   <= i_write_value;
        end
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_res.read_data;
    assign o_drive_state  = r_res.mode;
    assign o_read_lba     = r_res.lba;
    assign o_read_sectors = r_res.sectors;

endmodule

// ===== hdl/cdpt_msf.sv =====
// BCD minute/second/frame to logical block conversion, lead-in removed, clamped at 0.
// Depends on cdpt_pkg.
module cdpt_msf (
    input  logic [7:0]  i_min,
    input  logic [7:0]  i_sec,
    input  logic [7:0]  i_frm,
    output logic [19:0] o_lba
);
    import cdpt_pkg::*;

    logic [19:0] frames;

    assign frames = 20'(bcd_to_bin(i_min)) * FRAMES_PER_MIN
                  + 20'(bcd_to_bin(i_sec)) * FRAMES_PER_SEC
                  + 20'(bcd_to_bin(i_frm));

    assign o_lba = (frames >= LEAD_IN_FRAMES) ? frames - LEAD_IN_FRAMES : 20'd0;

endmodule

// ===== hdl/cdpt_packet.sv =====
// Packet assembly and execution engine: mode, packet store, counters, read target.
// Depends on cdpt_pkg and cdpt_msf; presents the post-transfer result.
module cdpt_packet #(
    parameter int PACKET_BYTES = cdpt_pkg::PACKET_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  cdpt_pkg::t_access i_acc,
    output cdpt_pkg::t_result o_res
);
    import cdpt_pkg::*;

    localparam int CW = $clog2(PACKET_BYTES + 1);
    localparam int IW = $clog2(PACKET_BYTES);

    t_mode       r_mode, n_mode;
    logic [7:0]  r_store [PACKET_BYTES];
    logic [7:0]  n_store [PACKET_BYTES];
    logic [CW-1:0] r_count, n_count;
    logic [2:0]  r_needed, n_needed;
    logic [19:0] r_lba, n_lba;
    logic [7:0]  r_sectors, n_sectors;
    logic        exec;
    logic        cmd_write;
    logic [19:0] msf_lba;

    assign cmd_write = i_take && (i_acc.cmd == ACC_WRITE) && (i_acc.reg_sel == REG_CMD);

    cdpt_msf u_msf (
        .i_min (n_store[READ_MIN_IDX]),
        .i_sec (n_store[READ_SEC_IDX]),
        .i_frm (n_store[READ_FRM_IDX]),
        .o_lba (msf_lba)
    );

    // next state
    always_comb begin
        n_store   = r_store;
        n_count   = r_count;
        n_needed  = r_needed;
        n_mode    = r_mode;
        n_lba     = r_lba;
        n_sectors = r_sectors;
        exec      = 1'b0;
        if (cmd_write) begin
            if (r_mode != MODE_RECEIVE) begin
                for (int i = 0; i < PACKET_BYTES; i++) begin
                    n_store[i] = 8'd0;
                end
                n_store[0] = i_acc.value;
                n_count    = CW'(1);
                n_needed   = packet_length(i_acc.value);
                n_mode     = MODE_RECEIVE;
            end else if (r_count < CW'(PACKET_BYTES)) begin
                n_store[r_count[IW-1:0]] = i_acc.value;
                n_count = r_count + CW'(1);
            end
            exec = (n_count >= CW'(n_needed));
        end
        if (exec) begin
            unique case (n_store[0]) inside
                OP_READ: begin
                    n_lba     = msf_lba;
                    n_sectors = (n_store[READ_COUNT_IDX] == 8'd0) ? 8'd1
                                                                 : n_store[READ_COUNT_IDX];
                    n_mode    = MODE_READ;
                end
                OP_DATA_A, OP_DATA_B: n_mode = MODE_DATA_OUT;
                default:              n_mode = MODE_STATUS;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_res.mode    = n_mode;
        o_res.lba     = n_lba;
        o_res.sectors = n_sectors;
        if (i_acc.cmd == ACC_WRITE) begin
            o_res.read_data = WRITE_BYTE;
        end else begin
            unique case (i_acc.reg_sel) inside
                REG_CMD:                  o_res.read_data = STATUS_BYTE;
                REG_PHASE, REG_PHASE_ALT: o_res.read_data = PHASE_BYTE;
                REG_AUX:                  o_res.read_data = FLOAT_BYTE;
                default:                  o_res.read_data = FLOAT_BYTE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_count   <= '0;
            r_needed  <= '0;
            r_lba     <= '0;
            r_sectors <= '0;
            for (int i = 0; i < PACKET_BYTES; i++) begin
                r_store[i] <= 8'd0;
            end
        end else begin
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_needed  <= n_needed;
            r_lba     <= n_lba;
            r_sectors <= n_sectors;
            r_store   <= n_store;
        end
    end

endmodule
